// File: hw/rtl/recent_word_repetition_detector_unit_defines.svh
// Assertion helpers shared by the RTL. Each expects clk and arst_n in scope.
`ifndef RECENT_WORD_REPETITION_DETECTOR_UNIT_DEFINES_SVH
`define RECENT_WORD_REPETITION_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RWRD_ASSERT_NOW(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("rwrd assertion failed");

// Next-cycle implication.
`define RWRD_ASSERT_NXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("rwrd assertion failed");

`endif

// File: hw/rtl/rwrd_pkg.sv
`timescale 1ns / 1ps

package rwrd_pkg;

	localparam int WORD_BYTES_DEF    = 64;
	localparam int HISTORY_SLOTS_DEF = 5;
	localparam int TEXT_BYTES        = 65536;
	localparam int POS_W             = $clog2(TEXT_BYTES);
	localparam int BUDGET_W          = 16;
	localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(256);
	localparam int MIN_WORD          = 3;

	// register index within the config space
	localparam logic REG_BUDGET = 1'b0;

	// broadcast from the control section to every slot cell
	typedef struct packed {
		logic [7:0]       letter;   // folded byte
		logic             app;      // letter appended this cycle
		logic             fin;      // word of MIN_WORD or more ends this cycle
		logic             use_now;  // ending word includes this cycle's letter
		logic             clr;      // end of text: drop history
		logic [7:0]       p0;       // first two letters of the ending word
		logic [7:0]       p1;
		logic [POS_W-1:0] fin_begin;
	} cell_ctl_t;

	// priority link: first matching slot wins
	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] start;
	} chain_t;

	function automatic logic is_sep(input logic [7:0] c);
		case (c)
			8'h20, 8'h0a, 8'h0d, 8'h09, 8'h2e, 8'h2c, 8'h21, 8'h3f,
			8'h3b, 8'h3a, 8'h22, 8'h28, 8'h29, 8'h27, 8'h2d: is_sep = 1'b1;
			default: is_sep = 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] fold_lower(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5a) begin
			fold_lower = c + 8'h20;
		end else begin
			fold_lower = c;
		end
	endfunction

endpackage

// File: hw/rtl/rwrd_cell.sv
`timescale 1ns / 1ps

// One history slot: stored word, incremental match flag, priority link.
module rwrd_cell #(
	parameter int WORD_BYTES = rwrd_pkg::WORD_BYTES_DEF,
	localparam int LEN_W = $clog2(WORD_BYTES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rwrd_pkg::cell_ctl_t ctl,
	input  logic               sel,       // this slot is the next to be replaced
	input  logic [LEN_W-1:0]   lidx,      // index of the incoming letter
	input  logic [LEN_W-1:0]   rd_addr,   // prefetch address for the next letter
	input  logic [LEN_W-1:0]   fin_len,
	input  rwrd_pkg::chain_t   chain_in,
	output rwrd_pkg::chain_t   chain_out
);

	logic [LEN_W-1:0]          len_q;
	logic [rwrd_pkg::POS_W-1:0] start_q;
	logic [7:0]                p0_q;
	logic [7:0]                p1_q;
	logic [7:0]                rd_q;
	logic                      match_q;
	logic [7:0]                mem_q [WORD_BYTES];

	logic [7:0] stored;
	logic       match_now;
	logic       flag;
	logic       hit;
	logic       store;

	// positions 0 and 1 live in flops so a short word never touches the memory
	assign stored    = (lidx == LEN_W'(0)) ? p0_q :
	                   (lidx == LEN_W'(1)) ? p1_q : rd_q;
	assign match_now = (stored == ctl.letter) && ((lidx == LEN_W'(0)) || match_q);
	assign flag      = ctl.use_now ? match_now : match_q;
	assign hit       = ctl.fin && flag && (len_q == fin_len);
	assign store     = ctl.fin && sel;

	assign chain_out.hit   = chain_in.hit || hit;
	assign chain_out.start = chain_in.hit ? chain_in.start : start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			match_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				len_q <= '0;
			end else if (store) begin
				len_q <= fin_len;
			end
			if (ctl.app) begin
				match_q <= match_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			start_q <= ctl.fin_begin;
			p0_q    <= ctl.p0;
			p1_q    <= ctl.p1;
		end
	end

	// old byte is read (prefetched) before the current word overwrites it
	always_ff @(posedge clk) begin
		if (ctl.app && sel && (lidx >= LEN_W'(2))) begin
			mem_q[lidx] <= ctl.letter;
		end
		rd_q <= mem_q[rd_addr];
	end

endmodule

// File: hw/rtl/recent_word_repetition_detector_unit.sv
`timescale 1ns / 1ps

// Recent word repetition detector. Text enters one byte per item on the s_ side (tlast
// marks the last byte of a text) and is split into words at space, LF, CR, TAB and
// . , ! ? ; : " ( ) ' -; letters fold to lower case. A word of three or more bytes is
// checked against the last HISTORY_SLOTS such words; on a match one item leaves on
// the m_ side with the word's start, its length and the start kept by the lowest
// numbered matching slot. Words hold at most WORD_BYTES-1 bytes; a further letter ends
// the word and is dropped. Once report_budget reports have gone out, bytes are ignored
// until the end of text, which always clears the history and the position count.
// Rate: one byte per cycle, sustained. A report sits in the output register in the cycle
// after its ending byte; input stalls only while that register is full and m_tready is
// low. The rate is set by the slot cells, which compare each letter as it arrives
// against a byte prefetched in the cycle before from each slot's word memory.
module recent_word_repetition_detector_unit #(
	parameter int WORD_BYTES    = rwrd_pkg::WORD_BYTES_DEF,
	parameter int HISTORY_SLOTS = rwrd_pkg::HISTORY_SLOTS_DEF,
	localparam int LEN_W  = $clog2(WORD_BYTES),
	localparam int OUT_W  = ((2 * rwrd_pkg::POS_W + LEN_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// text in
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // text_byte
	input  logic             s_tlast,   // end_of_text
	// reports out
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // repeat_start, word_length, earlier_start, zero pad
	// config
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int POS_W  = rwrd_pkg::POS_W;
	localparam int BUD_W  = rwrd_pkg::BUDGET_W;
	localparam int SLOT_W = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;
	localparam int PAD_W  = OUT_W - (2 * POS_W + LEN_W);

	// word under construction
	logic [LEN_W-1:0]  cur_len_q;
	logic [POS_W-1:0]  cur_begin_q;
	logic [7:0]        cur0_q;
	logic [7:0]        cur1_q;
	// history and text bookkeeping
	logic [SLOT_W-1:0] next_slot_q;
	logic [POS_W-1:0]  pos_q;
	logic [BUD_W-1:0]  issued_q;
	logic [BUD_W-1:0]  budget_q;
	// output register
	logic              out_valid_q;
	logic [POS_W-1:0]  out_start_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [POS_W-1:0]  out_early_q;

	logic             acc;
	logic             active;
	logic             proc;
	logic [7:0]       letter;
	logic             app;
	logic             fin_any;
	logic             fin_ok;
	logic [LEN_W-1:0] fin_len;
	logic [LEN_W-1:0] len_d;
	logic [POS_W-1:0] fin_begin;
	logic             report;
	logic             cfg_wr;

	rwrd_pkg::cell_ctl_t ctl;
	rwrd_pkg::chain_t    links [HISTORY_SLOTS+1];

	assign acc    = s_tvalid && s_tready;
	assign active = issued_q < budget_q;
	assign proc   = acc && active;
	assign letter = rwrd_pkg::fold_lower(s_tdata);

	// a letter is kept while the word has room; otherwise the byte ends the word
	assign app     = proc && !rwrd_pkg::is_sep(s_tdata) &&
	                 (cur_len_q < LEN_W'(WORD_BYTES - 1));
	// end of text folds the implicit separator into the same cycle
	assign fin_any = proc && (!app || s_tlast);
	assign fin_len = app ? (cur_len_q + LEN_W'(1)) : cur_len_q;
	assign fin_ok  = fin_any && (fin_len >= LEN_W'(rwrd_pkg::MIN_WORD));
	assign fin_begin = (app && (cur_len_q == '0)) ? pos_q : cur_begin_q;

	always_comb begin
		if (acc && s_tlast) begin
			len_d = '0;
		end else if (app) begin
			len_d = cur_len_q + LEN_W'(1);
		end else if (proc) begin
			len_d = '0;
		end else begin
			len_d = cur_len_q;
		end
	end

	assign ctl.letter    = letter;
	assign ctl.app       = app;
	assign ctl.fin       = fin_ok;
	assign ctl.use_now   = app;
	assign ctl.clr       = acc && s_tlast;
	assign ctl.p0        = cur0_q;
	assign ctl.p1        = cur1_q;
	assign ctl.fin_begin = fin_begin;

	// row of slot cells; the priority link runs from slot 0 upward
	assign links[0] = '0;

	for (genvar i = 0; i < HISTORY_SLOTS; i++) begin : g_slot
		rwrd_cell #(
			.WORD_BYTES(WORD_BYTES)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.sel      (next_slot_q == SLOT_W'(i)),
			.lidx     (cur_len_q),
			.rd_addr  (len_d),
			.fin_len  (fin_len),
			.chain_in (links[i]),
			.chain_out(links[i+1])
		);
	end

	assign report = fin_ok && links[HISTORY_SLOTS].hit;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_len_q   <= '0;
			cur_begin_q <= '0;
			next_slot_q <= '0;
			pos_q       <= '0;
			issued_q    <= '0;
		end else if (acc && s_tlast) begin
			cur_len_q   <= '0;
			cur_begin_q <= '0;
			next_slot_q <= '0;
			pos_q       <= '0;
			issued_q    <= '0;
		end else if (proc) begin
			cur_len_q   <= len_d;
			cur_begin_q <= fin_begin;
			pos_q       <= pos_q + POS_W'(1);
			if (fin_ok) begin
				next_slot_q <= (next_slot_q == SLOT_W'(HISTORY_SLOTS - 1)) ?
				               '0 : (next_slot_q + SLOT_W'(1));
			end
			if (report) begin
				issued_q <= issued_q + BUD_W'(1);
			end
		end
	end

	// first two letters of the word, handed to a slot when it is stored
	always_ff @(posedge clk) begin
		if (app && (cur_len_q == LEN_W'(0))) begin
			cur0_q <= letter;
		end
		if (app && (cur_len_q == LEN_W'(1))) begin
			cur1_q <= letter;
		end
	end

	// output register; frees up in the same cycle it is taken
	assign s_tready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && report) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && report) begin
			out_start_q <= fin_begin;
			out_len_q   <= fin_len;
			out_early_q <= links[HISTORY_SLOTS].start;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_early_q, out_len_q, out_start_q};

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == rwrd_pkg::REG_BUDGET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= rwrd_pkg::BUDGET_RESET;
		end else if (cfg_wr) begin
			budget_q <= pwdata[BUD_W-1:0];
		end
	end

	assign prdata = (paddr[2] == rwrd_pkg::REG_BUDGET) ? {{(32 - BUD_W){1'b0}}, budget_q} : '0;

`include "recent_word_repetition_detector_unit_defines.svh"

	`RWRD_ASSERT_NOW(a_len_bound, 1'b1, cur_len_q <= LEN_W'(WORD_BYTES - 1))
	`RWRD_ASSERT_NOW(a_slot_bound, 1'b1, next_slot_q <= SLOT_W'(HISTORY_SLOTS - 1))
	`RWRD_ASSERT_NXT(a_eot_clears, acc && s_tlast,
		(cur_len_q == '0) && (pos_q == '0) && (issued_q == '0) && (next_slot_q == '0))
	`RWRD_ASSERT_NXT(a_report_out, acc && report, m_tvalid)

endmodule
